FILE: rtl/midpoint_slope_interpolator_unit_defines.svh
// ----------------------------------------------------------------------------
// Midpoint slope interpolator - assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_SLOPE_INTERPOLATOR_UNIT_DEFINES_SVH
`define MIDPOINT_SLOPE_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset
`define MSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same-cycle implication checked outside reset
`define MSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MSI_ASSERT(lbl, clk, rstn, prop, msg)
`define MSI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/msi_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint slope interpolator - package
// Opcodes, status codes, controller/datapath interface structs and helpers.
// ----------------------------------------------------------------------------
package msi_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 16;
  // dividend width covers the 65-bit interpolation product
  localparam int unsigned DivW    = 65;
  localparam int unsigned DivCntW = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_RISING = 2'd2,
    ST_FEW        = 2'd3
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    capture;
    logic    clear;
    logic    first;
    logic    set_res;
    status_e res_code;
    logic    load_div_init;
    logic    eval_div_init;
    logic    div_step;
    logic    write_entry;
    logic    scan_init;
    logic    rd_req;
    logic    scan_adv;
    logic    take_rd;
    logic    eval_prep;
    logic    eval_mul;
    logic    eval_fin;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic have_first;
    logic table_full;
    logic table_empty;
    logic x_rising;
    logic div_run;
    logic mid_gt;
    logic at_first;
    logic at_last;
  } dp_stat_t;

  // saturate a 35-bit signed sum to signed Q16.16
  function automatic logic [DataW-1:0] sat_q16(input logic signed [34:0] v);
    logic [DataW-1:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/msi_ctrl.sv
// ----------------------------------------------------------------------------
// Midpoint slope interpolator - controller
// Sequences clear, load and evaluate transactions over the datapath.
// ----------------------------------------------------------------------------
module msi_ctrl
  import msi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECIDE = 11'b000_0000_0010,
    S_LDIV   = 11'b000_0000_0100,
    S_LWR    = 11'b000_0000_1000,
    S_SRD    = 11'b000_0001_0000,
    S_SCK    = 11'b000_0010_0000,
    S_EPREP  = 11'b000_0100_0000,
    S_EMUL   = 11'b000_1000_0000,
    S_EDIV   = 11'b001_0000_0000,
    S_EFIN   = 11'b010_0000_0000,
    S_RESP   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_RESP;
        case (stat_i.op)
          OP_CLEAR: begin
            cmd_o.clear   = 1'b1;
            cmd_o.set_res = 1'b1;
          end
          OP_LOAD: begin
            if (!stat_i.have_first) begin
              cmd_o.first   = 1'b1;
              cmd_o.set_res = 1'b1;
            end else if (stat_i.table_full) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_FULL;
            end else if (!stat_i.x_rising) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_NOT_RISING;
            end else begin
              cmd_o.load_div_init = 1'b1;
              state_d             = S_LDIV;
            end
          end
          OP_EVAL: begin
            if (stat_i.table_empty) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_FEW;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SRD;
            end
          end
          default: begin
            cmd_o.set_res = 1'b1;
          end
        endcase
      end
      S_LDIV: begin
        if (stat_i.div_run) begin
          cmd_o.div_step = 1'b1;
        end else begin
          state_d = S_LWR;
        end
      end
      S_LWR: begin
        cmd_o.write_entry = 1'b1;
        state_d           = S_RESP;
      end
      S_SRD: begin
        cmd_o.rd_req = 1'b1;
        state_d      = S_SCK;
      end
      S_SCK: begin
        if (stat_i.mid_gt) begin
          if (stat_i.at_first) begin
            cmd_o.take_rd = 1'b1;
            state_d       = S_RESP;
          end else begin
            cmd_o.eval_prep = 1'b1;
            state_d         = S_EPREP;
          end
        end else if (stat_i.at_last) begin
          cmd_o.take_rd = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = S_SRD;
        end
      end
      S_EPREP: begin
        cmd_o.eval_mul = 1'b1;
        state_d        = S_EMUL;
      end
      S_EMUL: begin
        cmd_o.eval_div_init = 1'b1;
        state_d             = S_EDIV;
      end
      S_EDIV: begin
        if (stat_i.div_run) begin
          cmd_o.div_step = 1'b1;
        end else begin
          state_d = S_EFIN;
        end
      end
      S_EFIN: begin
        cmd_o.eval_fin = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

FILE: rtl/msi_dp.sv
// ----------------------------------------------------------------------------
// Midpoint slope interpolator - datapath
// Entry tables, scan registers, shared restoring divider and result stage.
// ----------------------------------------------------------------------------
module msi_dp
  import msi_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  input  logic [1:0]       op_i,
  input  logic [DataW-1:0] point_x_i,
  input  logic [DataW-1:0] point_y_i,
  input  logic [DataW-1:0] position_i,
  output logic [DataW-1:0] value_o,
  output logic [1:0]       status_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // captured transaction
  op_e              op_q;
  logic [DataW-1:0] px_q, py_q, pos_q;

  // curve state
  logic             have_q;
  logic [CW-1:0]    ent_q;
  logic [DataW-1:0] lastx_q, lasty_q;

  // entry tables
  logic [DataW-1:0] mid_mem   [MAX_ENTRIES];
  logic [DataW-1:0] slope_mem [MAX_ENTRIES];
  logic [DataW-1:0] rd_mid_q, rd_slope_q;

  // scan and interpolation operands
  logic [CW-1:0]    idx_q;
  logic [DataW-1:0] x1_q, v1_q, tt_q, dd_q;
  logic [DataW:0]   mag_q;
  logic             neg_q;
  logic [DivW-1:0]  prod_q;

  // divider
  logic [DivW-1:0]    dvd_q, quo_q;
  logic [DataW-1:0]   rem_q, dsr_q;
  logic [DivCntW-1:0] cnt_q;

  // result
  logic [DataW-1:0] res_val_q;
  status_e          res_st_q;

  // load arithmetic
  logic [DataW:0]   dy, dy_mag, sum_x;
  logic [DataW-1:0] dx, mid_new, slope_sat;

  assign dy      = {py_q[DataW-1], py_q} - {lasty_q[DataW-1], lasty_q};
  assign dy_mag  = dy[DataW] ? (~dy + 1'b1) : dy;
  assign dx      = px_q - lastx_q;
  assign sum_x   = {px_q[DataW-1], px_q} + {lastx_q[DataW-1], lastx_q};
  assign mid_new = sum_x[DataW:1];

  // saturate signed quotient of the slope division
  always_comb begin
    if (neg_q) begin
      if ((|quo_q[DivW-1:DataW]) || (quo_q[DataW-1] && (|quo_q[DataW-2:0]))) begin
        slope_sat = 32'h8000_0000;
      end else begin
        slope_sat = ~quo_q[DataW-1:0] + 1'b1;
      end
    end else begin
      if (|quo_q[DivW-1:DataW-1]) begin
        slope_sat = 32'h7FFF_FFFF;
      end else begin
        slope_sat = quo_q[DataW-1:0];
      end
    end
  end

  // interpolation arithmetic
  logic [DataW:0]    dv, dv_mag;
  logic [DivW-1:0]   prod_d;
  logic [DataW+1:0]  term;
  logic signed [34:0] sum_v;

  assign dv     = {rd_slope_q[DataW-1], rd_slope_q} - {v1_q[DataW-1], v1_q};
  assign dv_mag = dv[DataW] ? (~dv + 1'b1) : dv;
  assign prod_d = {1'b0, 64'(mag_q[DataW-1:0] * tt_q)}
                + (mag_q[DataW] ? {1'b0, tt_q, 32'b0} : '0);
  assign term   = neg_q ? (~{1'b0, quo_q[DataW:0]} + 1'b1) : {1'b0, quo_q[DataW:0]};
  assign sum_v  = $signed({{3{v1_q[DataW-1]}}, v1_q}) + $signed({term[DataW+1], term});

  // divider step
  logic [DataW:0] div_trial, div_diff;
  logic           div_geq;

  assign div_trial = {rem_q, dvd_q[DivW-1]};
  assign div_diff  = div_trial - {1'b0, dsr_q};
  assign div_geq   = (div_trial >= {1'b0, dsr_q});

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      ent_q   <= '0;
      lastx_q <= '0;
      lasty_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        have_q  <= 1'b0;
        ent_q   <= '0;
        lastx_q <= '0;
        lasty_q <= '0;
      end
      if (cmd_i.first) begin
        have_q  <= 1'b1;
        lastx_q <= px_q;
        lasty_q <= py_q;
      end
      if (cmd_i.write_entry) begin
        ent_q   <= ent_q + 1'b1;
        lastx_q <= px_q;
        lasty_q <= py_q;
      end
      if (cmd_i.load_div_init || cmd_i.eval_div_init) begin
        cnt_q <= DivCntW'(DivW);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.scan_adv) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(op_i);
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      pos_q <= position_i;
    end
    if (cmd_i.scan_adv) begin
      x1_q <= rd_mid_q;
      v1_q <= rd_slope_q;
    end
    if (cmd_i.eval_prep) begin
      mag_q <= dv_mag;
      neg_q <= dv[DataW];
      tt_q  <= pos_q - x1_q;
      dd_q  <= rd_mid_q - x1_q;
    end
    if (cmd_i.eval_mul) begin
      prod_q <= prod_d;
    end
    // divider operands and iteration
    if (cmd_i.load_div_init) begin
      dvd_q <= {16'b0, dy_mag, 16'b0};
      dsr_q <= dx;
      neg_q <= dy[DataW];
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.eval_div_init) begin
      dvd_q <= prod_q;
      dsr_q <= dd_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      quo_q <= {quo_q[DivW-2:0], div_geq};
      rem_q <= div_geq ? div_diff[DataW-1:0] : div_trial[DataW-1:0];
    end
    // result stage
    if (cmd_i.set_res) begin
      res_val_q <= '0;
      res_st_q  <= cmd_i.res_code;
    end else if (cmd_i.write_entry) begin
      res_val_q <= '0;
      res_st_q  <= ST_OK;
    end else if (cmd_i.take_rd) begin
      res_val_q <= rd_slope_q;
      res_st_q  <= ST_OK;
    end else if (cmd_i.eval_fin) begin
      res_val_q <= sat_q16(sum_v);
      res_st_q  <= ST_OK;
    end
  end

  // entry table write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      mid_mem[ent_q[AW-1:0]]   <= mid_new;
      slope_mem[ent_q[AW-1:0]] <= slope_sat;
    end
    if (cmd_i.rd_req) begin
      rd_mid_q   <= mid_mem[idx_q[AW-1:0]];
      rd_slope_q <= slope_mem[idx_q[AW-1:0]];
    end
  end

  // status to controller
  assign stat_o.op          = op_q;
  assign stat_o.have_first  = have_q;
  assign stat_o.table_full  = (ent_q == CW'(MAX_ENTRIES));
  assign stat_o.table_empty = (ent_q == '0);
  assign stat_o.x_rising    = ($signed(px_q) > $signed(lastx_q));
  assign stat_o.div_run     = (cnt_q != '0);
  assign stat_o.mid_gt      = ($signed(rd_mid_q) > $signed(pos_q));
  assign stat_o.at_first    = (idx_q == '0);
  assign stat_o.at_last     = ((idx_q + 1'b1) == ent_q);

  assign value_o  = res_val_q;
  assign status_o = res_st_q;

endmodule

FILE: rtl/midpoint_slope_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Midpoint slope interpolator - top level
// Builds a midpoint/slope table from a raw curve and interpolates it.
// ----------------------------------------------------------------------------
// Usage: drive op_i and the operand ports and raise start_i; the transaction
// is taken at a clock edge where start_i is high and busy_o is low. busy_o
// stays high until the result has been shown. Each transaction produces one
// result on value_o/status_o, valid for the single cycle in which done_o is
// high; the receiver cannot hold it off and must take it then.
// Steps from the accepting edge to the done_o cycle:
//   clear, unused op, first point, rejected load or evaluate: decide only.
//   accepted load: decide, the 65-step restoring divider, the table write.
//   evaluate: decide, then per table entry scanned one registered table read
//   and one compare, plus multiply and divide to interpolate two entries.
// One transaction is in flight at a time; the next may be accepted the cycle
// after done_o. Reset empties the curve; the tables need no clearing pass.
// ----------------------------------------------------------------------------
`include "midpoint_slope_interpolator_unit_defines.svh"

module midpoint_slope_interpolator_unit
  import msi_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              op_i,
  input  logic signed [DataW-1:0] point_x_i,
  input  logic signed [DataW-1:0] point_y_i,
  input  logic signed [DataW-1:0] position_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] value_o,
  output logic [1:0]              status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  msi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // tables and arithmetic
  msi_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .op_i       (op_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .position_i (position_i),
    .value_o    (value_o),
    .status_o   (status_o)
  );

  // checks
  `MSI_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "done strobe longer than one cycle")
  `MSI_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "accepted transaction did not raise busy")
  `MSI_ASSERT_IMP(a_done_in_busy, clk_i, rst_ni, done_o, busy_o, "result shown while idle")
  `MSI_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, done_o && (status_o != ST_OK), value_o == '0, "rejected transaction carries a value")

endmodule
